// ===== src/nested_region_cycle_profiler_defines.svh =====
// assertion macros for the nested region cycle profiler
// used by the top level only; no other dependencies
`ifndef NESTED_REGION_CYCLE_PROFILER_DEFINES_SVH
`define NESTED_REGION_CYCLE_PROFILER_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication, clocked on aclk, held off during reset
`define NRCP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("nrcp assertion failed");
// next-cycle implication
`define NRCP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("nrcp assertion failed");
`else
`define NRCP_ASSERT_IMP(lbl, ante, cons)
`define NRCP_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== src/nrcp_pkg.sv =====
// shared constants, codes and types of the nested region cycle profiler
// no dependencies
package nrcp_pkg;

    localparam int ANCHOR_COUNT = 4096;
    localparam int STACK_DEPTH  = 64;

    localparam int DATA_W   = 64;
    localparam int ANCHOR_W = 12;
    localparam int AW       = (ANCHOR_COUNT > 1) ? $clog2(ANCHOR_COUNT) : 1;
    localparam int SAW      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int LVW      = $clog2(STACK_DEPTH + 1);

    localparam logic [1:0] ACT_ENTER = 2'd0;
    localparam logic [1:0] ACT_EXIT  = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    typedef struct packed {
        logic [DATA_W-1:0] hit;
        logic [DATA_W-1:0] incl;
        logic [DATA_W-1:0] excl;
    } table_row_t;

    typedef struct packed {
        logic [AW-1:0]     anchor;
        logic [AW-1:0]     parent;
        logic [DATA_W-1:0] saved;
        logic [DATA_W-1:0] start;
    } stack_entry_t;

    typedef struct packed {
        logic              sub;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
    } alu_req_t;

endpackage

// ===== src/nrcp_ram.sv =====
// generic single-write, single-read memory with registered read data
// no dependencies
module nrcp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/nrcp_alu.sv =====
// shared 64-bit add/subtract unit of the profiler sequencer
// depends on nrcp_pkg
module nrcp_alu (
    input  nrcp_pkg::alu_req_t           req,
    output logic [nrcp_pkg::DATA_W-1:0] y
);
    import nrcp_pkg::*;

    assign y = req.sub ? (req.a - req.b) : (req.a + req.b);

endmodule

// ===== src/nested_region_cycle_profiler.sv =====
// top level of the nested region cycle profiler: sequencer, stack and counter tables
// depends on nrcp_pkg, nrcp_ram, nrcp_alu and the assertion macro header
`include "nested_region_cycle_profiler_defines.svh"

// After reset the block sweeps the counter table to zero, one anchor per cycle,
// and takes no transfer until that is done. Then one item is worked at a time:
// an enter, a read or an exit on an empty stack goes through S_IDLE, S_FETCH
// and S_OUT before the next transfer; any other exit goes through S_IDLE,
// S_FETCH, S_EX_PAR, S_EX_ARD, S_EX_ANC, S_EX_HIT and S_OUT. The longer exit
// path comes from the counter table, one row access per cycle, being read and
// written for the parent and then the anchor, with every add and subtract
// going through one shared 64-bit adder. A finished result sits in the output
// register, so the next item is taken while it waits.
module nested_region_cycle_profiler (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [79:0]  s_tdata,   // anchor[11:0], timestamp[75:12], zero pad
    input  logic [1:0]   s_tuser,   // action[1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [271:0] m_tdata,   // anchor_out[11:0], elapsed[75:12],
                                    // exclusive_total[139:76], inclusive_total[203:140],
                                    // hit_total[267:204], zero pad
    output logic [1:0]   m_tuser    // status[1:0]
);
    import nrcp_pkg::*;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_FETCH  = 3'd2;
    localparam logic [2:0] S_EX_PAR = 3'd3;
    localparam logic [2:0] S_EX_ARD = 3'd4;
    localparam logic [2:0] S_EX_ANC = 3'd5;
    localparam logic [2:0] S_EX_HIT = 3'd6;
    localparam logic [2:0] S_OUT    = 3'd7;

    logic [2:0]        state_reg, state_next;
    logic [AW-1:0]     clr_idx_reg, clr_idx_next;
    logic [LVW-1:0]    level_reg, level_next;
    logic [AW-1:0]     parent_reg, parent_next;
    logic [1:0]        act_reg, act_next;
    logic [AW-1:0]     anc_reg, anc_next;
    logic [AW-1:0]     par_reg, par_next;
    logic [DATA_W-1:0] ts_reg, ts_next;
    logic [DATA_W-1:0] el_reg, el_next;
    logic [DATA_W-1:0] saved_reg, saved_next;
    logic [DATA_W-1:0] excl_reg, excl_next;
    logic [DATA_W-1:0] incl_reg, incl_next;
    logic [1:0]        res_stat_reg, res_stat_next;
    logic [AW-1:0]     res_anc_reg, res_anc_next;
    logic [DATA_W-1:0] res_el_reg, res_el_next;
    table_row_t        res_row_reg, res_row_next;

    logic              m_tvalid_reg;
    logic [271:0]      m_tdata_reg;
    logic [1:0]        m_tuser_reg;
    logic              out_load;

    logic              tbl_we, tbl_re;
    logic [AW-1:0]     tbl_waddr, tbl_raddr;
    table_row_t        tbl_wdata, tbl_rdata;

    logic              stk_we, stk_re;
    logic [SAW-1:0]    stk_waddr, stk_raddr;
    stack_entry_t      stk_wdata, stk_rdata;

    alu_req_t          alu_req;
    logic [DATA_W-1:0] alu_y;

    logic              s_fire;
    logic              stk_full;
    logic              stk_empty;
    logic [LVW-1:0]    level_dec;

    assign s_fire    = s_tvalid && s_tready;
    assign stk_full  = (level_reg == LVW'(STACK_DEPTH));
    assign stk_empty = (level_reg == '0);
    assign level_dec = level_reg - LVW'(1);

    nrcp_ram #(
        .WIDTH ($bits(table_row_t)),
        .DEPTH (ANCHOR_COUNT),
        .AW    (AW)
    ) u_table (
        .aclk  (aclk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .re    (tbl_re),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    nrcp_ram #(
        .WIDTH ($bits(stack_entry_t)),
        .DEPTH (STACK_DEPTH),
        .AW    (SAW)
    ) u_stack (
        .aclk  (aclk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (stk_re),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    nrcp_alu u_alu (
        .req (alu_req),
        .y   (alu_y)
    );

    always_comb begin
        state_next    = state_reg;
        clr_idx_next  = clr_idx_reg;
        level_next    = level_reg;
        parent_next   = parent_reg;
        act_next      = act_reg;
        anc_next      = anc_reg;
        par_next      = par_reg;
        ts_next       = ts_reg;
        el_next       = el_reg;
        saved_next    = saved_reg;
        excl_next     = excl_reg;
        incl_next     = incl_reg;
        res_stat_next = res_stat_reg;
        res_anc_next  = res_anc_reg;
        res_el_next   = res_el_reg;
        res_row_next  = res_row_reg;
        s_tready      = 1'b0;
        out_load      = 1'b0;
        tbl_we        = 1'b0;
        tbl_waddr     = anc_reg;
        tbl_wdata     = '0;
        tbl_re        = 1'b0;
        tbl_raddr     = anc_reg;
        stk_we        = 1'b0;
        stk_waddr     = level_reg[SAW-1:0];
        stk_wdata     = '0;
        stk_re        = 1'b0;
        stk_raddr     = level_dec[SAW-1:0];
        alu_req.sub   = 1'b0;
        alu_req.a     = el_reg;
        alu_req.b     = saved_reg;

        unique case (state_reg)
            S_CLEAR: begin
                tbl_we       = 1'b1;
                tbl_waddr    = clr_idx_reg;
                clr_idx_next = clr_idx_reg + AW'(1);
                if (clr_idx_reg == AW'(ANCHOR_COUNT - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_fire) begin
                    act_next  = s_tuser;
                    // anchor count is a power of two: the modulo is a truncation
                    anc_next  = s_tdata[AW-1:0];
                    ts_next   = s_tdata[75:12];
                    tbl_re    = 1'b1;
                    tbl_raddr = s_tdata[AW-1:0];
                    stk_re    = 1'b1;
                    state_next = S_FETCH;
                end
            end
            S_FETCH: begin
                res_stat_next = STAT_OK;
                res_anc_next  = anc_reg;
                res_el_next   = '0;
                res_row_next  = tbl_rdata;
                state_next    = S_OUT;
                case (act_reg)
                    ACT_ENTER: begin
                        if (stk_full) begin
                            res_stat_next = STAT_FULL;
                        end else begin
                            stk_we           = 1'b1;
                            stk_wdata.anchor = anc_reg;
                            stk_wdata.parent = parent_reg;
                            stk_wdata.saved  = tbl_rdata.incl;
                            stk_wdata.start  = ts_reg;
                            level_next       = level_reg + LVW'(1);
                            parent_next      = anc_reg;
                        end
                    end
                    ACT_EXIT: begin
                        if (stk_empty) begin
                            res_stat_next = STAT_EMPTY;
                            res_anc_next  = '0;
                            res_row_next  = '0;
                        end else begin
                            alu_req.sub = 1'b1;
                            alu_req.a   = ts_reg;
                            alu_req.b   = stk_rdata.start;
                            el_next     = alu_y;
                            anc_next    = stk_rdata.anchor;
                            par_next    = stk_rdata.parent;
                            saved_next  = stk_rdata.saved;
                            level_next  = level_dec;
                            parent_next = stk_rdata.parent;
                            tbl_re      = 1'b1;
                            tbl_raddr   = stk_rdata.parent;
                            state_next  = S_EX_PAR;
                        end
                    end
                    default: begin
                        // read, and the unused code treated as a read
                    end
                endcase
            end
            S_EX_PAR: begin
                alu_req.sub    = 1'b1;
                alu_req.a      = tbl_rdata.excl;
                alu_req.b      = el_reg;
                tbl_we         = 1'b1;
                tbl_waddr      = par_reg;
                tbl_wdata      = tbl_rdata;
                tbl_wdata.excl = alu_y;
                state_next     = S_EX_ARD;
            end
            S_EX_ARD: begin
                // anchor row read after the parent write, so self-recursion sees it
                tbl_re      = 1'b1;
                tbl_raddr   = anc_reg;
                alu_req.a   = saved_reg;
                alu_req.b   = el_reg;
                incl_next   = alu_y;
                state_next  = S_EX_ANC;
            end
            S_EX_ANC: begin
                alu_req.a  = tbl_rdata.excl;
                alu_req.b  = el_reg;
                excl_next  = alu_y;
                state_next = S_EX_HIT;
            end
            S_EX_HIT: begin
                alu_req.a      = tbl_rdata.hit;
                alu_req.b      = DATA_W'(1);
                tbl_we         = 1'b1;
                tbl_waddr      = anc_reg;
                tbl_wdata.excl = excl_reg;
                tbl_wdata.incl = incl_reg;
                tbl_wdata.hit  = alu_y;
                res_stat_next  = STAT_OK;
                res_anc_next   = anc_reg;
                res_el_next    = el_reg;
                res_row_next   = tbl_wdata;
                state_next     = S_OUT;
            end
            S_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_idx_reg  <= '0;
            level_reg    <= '0;
            parent_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_idx_reg <= clr_idx_next;
            level_reg   <= level_next;
            parent_reg  <= parent_next;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        act_reg      <= act_next;
        anc_reg      <= anc_next;
        par_reg      <= par_next;
        ts_reg       <= ts_next;
        el_reg       <= el_next;
        saved_reg    <= saved_next;
        excl_reg     <= excl_next;
        incl_reg     <= incl_next;
        res_stat_reg <= res_stat_next;
        res_anc_reg  <= res_anc_next;
        res_el_reg   <= res_el_next;
        res_row_reg  <= res_row_next;
        if (out_load) begin
            m_tuser_reg <= res_stat_reg;
            m_tdata_reg <= {4'b0, res_row_reg.hit, res_row_reg.incl, res_row_reg.excl,
                            res_el_reg, ANCHOR_W'(res_anc_reg)};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `NRCP_ASSERT_IMP(a_level_bound, 1'b1, level_reg <= LVW'(STACK_DEPTH))
    `NRCP_ASSERT_IMP(a_no_take_in_clear, state_reg == S_CLEAR, !s_tready)
    `NRCP_ASSERT_NXT(a_empty_exit_level, s_fire && s_tuser == ACT_EXIT && stk_empty, stk_empty)
    `NRCP_ASSERT_IMP(a_empty_result_zero, m_tvalid && m_tuser == STAT_EMPTY, m_tdata == '0)

endmodule
